@@ sv/bsdc_pkg.sv @@
// -----------------------------------------------------------------------------
// bsdc_pkg: shared types and constants for the Bezier split block
// Request payloads, the sequencer states and the fixed-point constants.
// -----------------------------------------------------------------------------
package bsdc_pkg;

	localparam int MAX_POINTS_DEF = 16;

	// Unsigned Q1.16 one, and the half LSB added before the Q16.16 floor.
	localparam logic [16:0] T_ONE      = 17'd65536;
	localparam int          ROUND_HALF = 32768;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic        [16:0] split_t;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic               half;
		logic        [4:0]  position;
		logic               last_result;
		logic               overflow;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MX,
		S_MY,
		S_AY,
		S_ORD,
		S_OSHOW
	} state_t;

endpackage

@@ sv/bsdc_lerp.sv @@
// -----------------------------------------------------------------------------
// bsdc_lerp: shared interpolation unit
// One coordinate of p + t*(q - p) per use; the product is registered and the
// rounded Q16.16 sum is formed from it in the following cycle.
// -----------------------------------------------------------------------------
module bsdc_lerp (
	input  logic               clk,
	input  logic               mul_en,
	input  logic signed [31:0] p,
	input  logic signed [31:0] q,
	input  logic        [16:0] t,
	output logic signed [31:0] res
);
	import bsdc_pkg::*;

	logic signed [32:0] diff;
	logic signed [50:0] prod;
	logic signed [50:0] prod_q;
	logic signed [31:0] p_q;
	logic signed [50:0] biased;
	logic signed [50:0] shifted;

	assign diff = $signed({q[31], q}) - $signed({p[31], p});
	assign prod = diff * $signed({1'b0, t});

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod;
			p_q    <= p;
		end
	end

	// Arithmetic shift gives the floor, so adding half first rounds half up.
	assign biased  = prod_q + 51'(ROUND_HALF);
	assign shifted = biased >>> 16;
	assign res     = shifted[31:0] + p_q;

endmodule

@@ sv/bezier_split_de_casteljau.sv @@
// -----------------------------------------------------------------------------
// bezier_split_de_casteljau: de Casteljau subdivision of a 2-D Bezier curve
// Control points are loaded one request per cycle while the block is idle; the
// request marked as the last point carries t and starts the split. The triangle
// of interpolations runs on one shared interpolation unit; each row opens with a
// registered read of the working memory, and each interpolation then steps
// through the x product, the y product and the write-back. The 2n result points
// then leave one by one, each by a registered read of the sub-curve memories and
// then the request, held while the receiver stalls. No point is accepted from
// the split until the final right-half point has been taken.
// -----------------------------------------------------------------------------
module bezier_split_de_casteljau #(
	parameter int MAX_POINTS = bsdc_pkg::MAX_POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             point_valid,
	output logic             point_stall,
	input  bsdc_pkg::point_t point,
	output logic             result_valid,
	input  logic             result_stall,
	output bsdc_pkg::result_t result
);
	import bsdc_pkg::*;

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic [16:0]   t_q;
	logic [IW-1:0] order_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] pos_q;
	logic          half_q;
	logic [31:0]   res_x_q;

	logic [63:0] work_mem  [0:MAX_POINTS-1];
	logic [63:0] left_mem  [0:MAX_POINTS-1];
	logic [63:0] right_mem [0:MAX_POINTS-1];
	logic [63:0] work_a_q, work_b_q;
	logic [63:0] left_rd_q, right_rd_q;

	logic          accept;
	logic          store_ok;
	logic [CW-1:0] count_inc;
	logic [CW-1:0] n_last;
	logic [IW-1:0] order_new;
	logic [IW-1:0] last_i;
	logic          pass_end;
	logic          split_end;
	logic          half_end;
	logic [16:0]   t_sat;

	logic          wk_rd_en;
	logic          out_rd_en;
	logic          mul_en;
	logic          sel_y;
	logic          ay_wr;
	logic [IW-1:0] rd_base;
	logic [IW-1:0] addr_a;
	logic [IW-1:0] addr_b;
	logic signed [31:0] lerp_p, lerp_q, lerp_res;

	assign accept    = point_valid && !point_stall;
	assign store_ok  = count_q < CW'(MAX_POINTS);
	assign count_inc = count_q + CW'(1);
	assign n_last    = store_ok ? count_inc : count_q;
	assign order_new = IW'(n_last - CW'(1));
	assign last_i    = order_q - k_q;
	assign pass_end  = i_q == last_i;
	assign split_end = k_q == order_q;
	assign half_end  = pos_q == order_q;
	assign t_sat     = (point.split_t > T_ONE) ? T_ONE : point.split_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		wk_rd_en     = 1'b0;
		out_rd_en    = 1'b0;
		mul_en       = 1'b0;
		sel_y        = 1'b0;
		ay_wr        = 1'b0;
		result_valid = 1'b0;
		point_stall  = 1'b1;
		case (state_q)
			S_IDLE: begin
				point_stall = 1'b0;
				if (point_valid && point.last_point) begin
					state_d = (order_new == '0) ? S_ORD : S_RD;
				end
			end
			S_RD: begin
				wk_rd_en = 1'b1;
				state_d  = S_MX;
			end
			S_MX: begin
				mul_en  = 1'b1;
				state_d = S_MY;
			end
			S_MY: begin
				mul_en  = 1'b1;
				sel_y   = 1'b1;
				state_d = S_AY;
			end
			S_AY: begin
				ay_wr = 1'b1;
				if (pass_end) begin
					state_d = split_end ? S_ORD : S_RD;
				end else begin
					// The next pair never includes the entry being written here.
					wk_rd_en = 1'b1;
					state_d  = S_MX;
				end
			end
			S_ORD: begin
				out_rd_en = 1'b1;
				state_d   = S_OSHOW;
			end
			S_OSHOW: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					state_d = (half_q && half_end) ? S_IDLE : S_ORD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			t_q       <= '0;
			order_q   <= '0;
			k_q       <= '0;
			i_q       <= '0;
			pos_q     <= '0;
			half_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (store_ok) begin
							count_q <= count_inc;
						end else begin
							dropped_q <= 1'b1;
						end
						if (point.last_point) begin
							t_q     <= t_sat;
							order_q <= order_new;
							k_q     <= IW'(1);
							i_q     <= '0;
							pos_q   <= '0;
							half_q  <= 1'b0;
						end
					end
				end
				S_AY: begin
					if (pass_end) begin
						k_q <= k_q + IW'(1);
						i_q <= '0;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				S_OSHOW: begin
					if (!result_stall) begin
						if (half_end) begin
							pos_q <= '0;
							if (half_q) begin
								count_q   <= '0;
								dropped_q <= 1'b0;
							end else begin
								half_q <= 1'b1;
							end
						end else begin
							pos_q <= pos_q + IW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_base = (state_q == S_AY) ? (i_q + IW'(1)) : i_q;
	assign addr_a  = rd_base;
	assign addr_b  = rd_base + IW'(1);

	// Every stored point overwrites right entry 0, so it ends up holding the
	// original end point; left entry 0 takes only the first point.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && store_ok) begin
			work_mem[IW'(count_q)] <= {point.point_y, point.point_x};
			right_mem[0]           <= {point.point_y, point.point_x};
			if (count_q == '0) begin
				left_mem[0] <= {point.point_y, point.point_x};
			end
		end else if (ay_wr) begin
			work_mem[i_q] <= {lerp_res, res_x_q};
			if (i_q == '0) begin
				left_mem[k_q] <= {lerp_res, res_x_q};
			end
			if (pass_end) begin
				right_mem[k_q] <= {lerp_res, res_x_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wk_rd_en) begin
			work_a_q <= work_mem[addr_a];
			work_b_q <= work_mem[addr_b];
		end
		if (out_rd_en) begin
			left_rd_q  <= left_mem[pos_q];
			right_rd_q <= right_mem[pos_q];
		end
		if (state_q == S_MY) begin
			res_x_q <= lerp_res;
		end
	end

	assign lerp_p = sel_y ? work_a_q[63:32] : work_a_q[31:0];
	assign lerp_q = sel_y ? work_b_q[63:32] : work_b_q[31:0];

	bsdc_lerp u_lerp (
		.clk    (clk),
		.mul_en (mul_en),
		.p      (lerp_p),
		.q      (lerp_q),
		.t      (t_q),
		.res    (lerp_res)
	);

	always_comb begin
		result.out_x       = half_q ? right_rd_q[31:0]  : left_rd_q[31:0];
		result.out_y       = half_q ? right_rd_q[63:32] : left_rd_q[63:32];
		result.half        = half_q;
		result.position    = 5'(pos_q);
		result.last_result = half_q && half_end;
		result.overflow    = dropped_q;
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond capacity");

	a_out_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (count_q != '0 && pos_q <= order_q))
		else $error("result presented without stored points");

	a_triangle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MX || state_q == S_MY || state_q == S_AY)
		|-> (k_q != '0 && k_q <= order_q && i_q <= last_i))
		else $error("interpolation index outside the triangle");

	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.last_result)
		|=> (count_q == '0 && !dropped_q && state_q == S_IDLE))
		else $error("run not cleared after final result");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q) || state_q == S_IDLE)
		else $error("point count changed during split");
`endif

endmodule
